// ===== sv/lcbc_pkg.sv =====
package lcbc_pkg;

	// fixed field widths
	localparam int ACTION_W = 2;
	localparam int LETTER_W = 5;
	localparam int SCORE_W  = 8;
	localparam int BG_W     = 16;
	localparam int POS_W    = 16;
	localparam int CORR_W   = 17;
	localparam int ASZ_W    = 6;

	// parameter defaults
	localparam int WINDOW_DEF       = 40;
	localparam int ALPHABET_MAX_DEF = 32;
	localparam int RING_DEPTH_DEF   = 64;
	localparam int MAX_LENGTH_DEF   = 65536;

	localparam logic [ASZ_W-1:0] ASZ_RESET = 6'd21;

	// arithmetic width of the correction engine
	localparam int ACC_W    = 48;
	localparam int PROD_W   = 25;
	localparam int CORR_MAX = 65535;
	localparam int CORR_MIN = -65536;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SCORE = 2'd0,
		ACT_BG    = 2'd1,
		ACT_RES   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// controller to datapath commands
	typedef struct packed {
		logic score_we;
		logic bg_we;
		logic ring_we;
		logic start;
		logic zero;
	} cmd_t;

endpackage

// ===== sv/lcbc_dp.sv =====
module lcbc_dp #(
	parameter int WINDOW       = lcbc_pkg::WINDOW_DEF,
	parameter int ALPHABET_MAX = lcbc_pkg::ALPHABET_MAX_DEF,
	parameter int RING_DEPTH   = lcbc_pkg::RING_DEPTH_DEF,
	parameter int MAX_LENGTH   = lcbc_pkg::MAX_LENGTH_DEF,
	localparam int CW  = $clog2(MAX_LENGTH + 1),
	localparam int RAW = $clog2(RING_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lcbc_pkg::cmd_t                    cmd,
	input  logic [lcbc_pkg::ASZ_W-1:0]        alphabet_size,
	input  logic [lcbc_pkg::LETTER_W-1:0]     table_row,
	input  logic [lcbc_pkg::LETTER_W-1:0]     table_col,
	input  logic signed [lcbc_pkg::SCORE_W-1:0] score_value,
	input  logic [lcbc_pkg::BG_W-1:0]         background_value,
	input  logic [lcbc_pkg::LETTER_W-1:0]     residue,
	input  logic [RAW-1:0]                    ring_widx,
	input  logic [CW-1:0]                     pos,
	input  logic [RAW-1:0]                    pos_idx,
	input  logic [CW-1:0]                     len,
	output logic                              done,
	output logic signed [lcbc_pkg::CORR_W-1:0] result
);

	localparam int H      = WINDOW / 2;
	localparam int SW     = $clog2(WINDOW + 1);
	localparam int AW     = $clog2(ALPHABET_MAX);
	localparam int LW     = lcbc_pkg::LETTER_W;
	localparam int ACC_W  = lcbc_pkg::ACC_W;
	localparam int STEP_W = $clog2(ACC_W);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(lcbc_pkg::CORR_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(lcbc_pkg::CORR_MIN);

	typedef enum logic [8:0] {
		P_IDLE = 9'b000000001,
		P_ROW  = 9'b000000010,
		P_CAP  = 9'b000000100,
		P_WIN  = 9'b000001000,
		P_BG   = 9'b000010000,
		P_MUL  = 9'b000100000,
		P_PRE  = 9'b001000000,
		P_DIV  = 9'b010000000,
		P_SAT  = 9'b100000000
	} phase_t;

	phase_t phase_q;

	// memories
	logic signed [lcbc_pkg::SCORE_W-1:0] score_mem [1 << (2 * AW)];
	logic [lcbc_pkg::BG_W-1:0]           bg_mem [ALPHABET_MAX];
	logic [LW-1:0]                       ring_mem [RING_DEPTH];

	logic signed [lcbc_pkg::SCORE_W-1:0] score_q;
	logic [lcbc_pkg::BG_W-1:0]           bg_q;
	logic [LW-1:0]                       ring_q;
	logic [2*AW-1:0]                     score_raddr;
	logic [RAW-1:0]                      ring_raddr;

	// engine registers
	logic [CW-1:0]   pos_q;
	logic [RAW-1:0]  pos_idx_q;
	logic [CW:0]     hi_q;
	logic [CW:0]     j_q;
	logic [RAW-1:0]  jidx_q;
	logic [SW-1:0]   span_q;
	logic [LW-1:0]   row_q;
	logic [AW:0]     a_q;
	logic [AW:0]     lim_q;
	logic            w_v1_s1, w_v2_s2;
	logic            b_v1_s1, b_v2_s2;
	logic signed [lcbc_pkg::PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] s_acc_q, b_acc_q, n_q;
	logic            neg_q;
	logic [SW-1:0]   rem_q;
	logic [ACC_W-1:0] dvd_q;
	logic [STEP_W-1:0] step_q;
	logic            done_q;
	logic signed [lcbc_pkg::CORR_W-1:0] result_q;

	// start-time window bounds
	logic [CW-1:0]  lo;
	logic [CW:0]    hi_top;
	logic [CW:0]    hi;
	logic [SW-1:0]  back_n;
	logic [RAW:0]   idx_sum;
	logic [RAW-1:0] lo_idx;
	logic [AW:0]    lim;

	// sweep control
	logic win_iss, bg_iss, row_ok, col_ok;

	// finish arithmetic
	logic signed [ACC_W-1:0] x_pre;
	logic [ACC_W-1:0]        m_pre;
	logic [SW:0]             div_t;
	logic                    div_ge;
	logic signed [ACC_W-1:0] q_fin;

	always_comb begin
		lo      = (pos >= CW'(H)) ? pos - CW'(H) : '0;
		hi_top  = (CW+1)'(pos) + (CW+1)'(H);
		hi      = (hi_top < (CW+1)'(len)) ? hi_top : (CW+1)'(len);
		back_n  = SW'(pos - lo);
		idx_sum = (RAW+1)'(pos_idx) + (RAW+1)'(RING_DEPTH) - (RAW+1)'(back_n);
		lo_idx  = (idx_sum >= (RAW+1)'(RING_DEPTH)) ?
			RAW'(idx_sum - (RAW+1)'(RING_DEPTH)) : RAW'(idx_sum);
		lim     = (int'(alphabet_size) < ALPHABET_MAX) ?
			(AW+1)'(alphabet_size) : (AW+1)'(ALPHABET_MAX);
	end

	always_comb begin
		win_iss = (phase_q == P_WIN) && (j_q < hi_q);
		bg_iss  = (phase_q == P_BG) && (a_q < lim_q);
		row_ok  = int'(row_q) < ALPHABET_MAX;
		col_ok  = int'(ring_q) < ALPHABET_MAX;
		ring_raddr  = (phase_q == P_WIN) ? jidx_q : pos_idx_q;
		score_raddr = (phase_q == P_BG) ? {AW'(row_q), AW'(a_q)} :
			{AW'(row_q), AW'(ring_q)};
	end

	always_comb begin
		x_pre  = ((n_q <<< 1) + $signed({1'b0, span_q, 8'd0})) >>> 9;
		m_pre  = (x_pre < 0) ? ACC_W'(-x_pre + $signed({1'b0, span_q}) - 1) :
			ACC_W'(x_pre);
		div_t  = {rem_q, dvd_q[ACC_W-1]};
		div_ge = div_t >= {1'b0, span_q};
		q_fin  = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
	end

	// table and ring storage, registered reads
	always_ff @(posedge clk) begin
		if (cmd.score_we && int'(table_row) < ALPHABET_MAX &&
				int'(table_col) < ALPHABET_MAX) begin
			score_mem[{AW'(table_row), AW'(table_col)}] <= score_value;
		end
		score_q <= score_mem[score_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.bg_we && int'(table_col) < ALPHABET_MAX) begin
			bg_mem[AW'(table_col)] <= background_value;
		end
		bg_q <= bg_mem[AW'(a_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_we) begin
			ring_mem[ring_widx] <= residue;
		end
		ring_q <= ring_mem[ring_raddr];
	end

	// sweep pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_v1_s1 <= 1'b0;
			w_v2_s2 <= 1'b0;
			b_v1_s1 <= 1'b0;
			b_v2_s2 <= 1'b0;
		end else begin
			w_v1_s1 <= win_iss && (j_q != (CW+1)'(pos_q));
			w_v2_s2 <= w_v1_s1 && row_ok && col_ok;
			b_v1_s1 <= bg_iss && row_ok;
			b_v2_s2 <= b_v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(score_q) * $signed({1'b0, bg_q});
	end

	// engine sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (cmd.start && cmd.zero) begin
						done_q <= 1'b1;
					end else if (cmd.start) begin
						phase_q <= P_ROW;
					end
				end
				P_ROW: phase_q <= P_CAP;
				P_CAP: phase_q <= P_WIN;
				P_WIN: begin
					if (!win_iss && !w_v1_s1 && !w_v2_s2) begin
						phase_q <= P_BG;
					end
				end
				P_BG: begin
					if (!bg_iss && !b_v1_s1 && !b_v2_s2) begin
						phase_q <= P_MUL;
					end
				end
				P_MUL: phase_q <= P_PRE;
				P_PRE: phase_q <= P_DIV;
				P_DIV: begin
					if (step_q == STEP_W'(ACC_W - 1)) begin
						phase_q <= P_SAT;
					end
				end
				P_SAT: begin
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// engine payload
	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && cmd.start) begin
			pos_q     <= pos;
			pos_idx_q <= pos_idx;
			hi_q      <= hi;
			j_q       <= (CW+1)'(lo);
			jidx_q    <= lo_idx;
			span_q    <= SW'(hi - (CW+1)'(lo));
			lim_q     <= lim;
			a_q       <= '0;
			s_acc_q   <= '0;
			b_acc_q   <= '0;
			if (cmd.zero) begin
				result_q <= '0;
			end
		end
		if (phase_q == P_CAP) begin
			row_q <= ring_q;
		end
		if (win_iss) begin
			j_q    <= j_q + 1'b1;
			jidx_q <= (jidx_q == RAW'(RING_DEPTH - 1)) ? '0 : jidx_q + 1'b1;
		end
		if (w_v2_s2) begin
			s_acc_q <= s_acc_q + ACC_W'(score_q);
		end
		if (bg_iss) begin
			a_q <= a_q + 1'b1;
		end
		if (b_v2_s2) begin
			b_acc_q <= b_acc_q + ACC_W'(prod_s2);
		end
		if (phase_q == P_MUL) begin
			n_q <= b_acc_q * $signed({1'b0, span_q}) - (s_acc_q <<< 16);
		end
		if (phase_q == P_PRE) begin
			neg_q  <= x_pre < 0;
			dvd_q  <= m_pre;
			rem_q  <= '0;
			step_q <= '0;
		end
		// one quotient bit per cycle
		if (phase_q == P_DIV) begin
			rem_q  <= div_ge ? SW'(div_t - {1'b0, span_q}) : SW'(div_t);
			dvd_q  <= {dvd_q[ACC_W-2:0], div_ge};
			step_q <= step_q + 1'b1;
		end
		if (phase_q == P_SAT) begin
			if (q_fin > SAT_HI) begin
				result_q <= lcbc_pkg::CORR_W'(SAT_HI);
			end else if (q_fin < SAT_LO) begin
				result_q <= lcbc_pkg::CORR_W'(SAT_LO);
			end else begin
				result_q <= lcbc_pkg::CORR_W'(q_fin);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/lcbc_ctrl.sv =====
module lcbc_ctrl #(
	parameter int WINDOW     = lcbc_pkg::WINDOW_DEF,
	parameter int RING_DEPTH = lcbc_pkg::RING_DEPTH_DEF,
	parameter int MAX_LENGTH = lcbc_pkg::MAX_LENGTH_DEF,
	localparam int CW  = $clog2(MAX_LENGTH + 1),
	localparam int RAW = $clog2(RING_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lcbc_pkg::ACTION_W-1:0]      action,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lcbc_pkg::POS_W-1:0]         position,
	output logic signed [lcbc_pkg::CORR_W-1:0] correction,
	output logic                               last_result,
	output lcbc_pkg::cmd_t                     cmd,
	output logic [RAW-1:0]                     ring_widx,
	output logic [CW-1:0]                      pos,
	output logic [RAW-1:0]                     pos_idx,
	output logic [CW-1:0]                      len,
	input  logic                               dp_done,
	input  logic signed [lcbc_pkg::CORR_W-1:0] dp_result
);

	localparam int H = WINDOW / 2;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_WAIT  = 4'b0100,
		S_PUT   = 4'b1000
	} state_t;

	state_t state_q;

	logic [CW-1:0]  count_q, emitted_q, len_q, upto_q;
	logic [RAW-1:0] wr_idx_q, emit_idx_q;
	logic           zero_q, fin_q;
	logic           out_valid_q, last_q;
	logic [lcbc_pkg::POS_W-1:0]         position_q;
	logic signed [lcbc_pkg::CORR_W-1:0] corr_q;

	logic          take, is_res, full, go_last, go_mid, slot_free, at_end;
	logic [CW-1:0] cnt_next;

	// decode the accepted beat
	always_comb begin
		in_stall  = state_q != S_IDLE;
		take      = in_valid && !in_stall;
		is_res    = take && (action == lcbc_pkg::ACT_RES);
		full      = count_q == CW'(MAX_LENGTH);
		cnt_next  = full ? count_q : count_q + 1'b1;
		go_last   = is_res && last;
		go_mid    = is_res && !last && !full && (cnt_next >= CW'(WINDOW + 1));
		slot_free = !out_valid_q || !out_stall;
		at_end    = emitted_q == upto_q;
	end

	always_comb begin
		cmd.score_we = take && (action == lcbc_pkg::ACT_SCORE);
		cmd.bg_we    = take && (action == lcbc_pkg::ACT_BG);
		cmd.ring_we  = is_res && !full;
		cmd.start    = state_q == S_START;
		cmd.zero     = zero_q;
	end

	// sequence counters and emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			emitted_q  <= '0;
			wr_idx_q   <= '0;
			emit_idx_q <= '0;
			len_q      <= '0;
			upto_q     <= '0;
			zero_q     <= 1'b0;
			fin_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.ring_we) begin
						count_q  <= cnt_next;
						wr_idx_q <= (wr_idx_q == RAW'(RING_DEPTH - 1)) ?
							'0 : wr_idx_q + 1'b1;
					end
					if (go_last || go_mid) begin
						len_q   <= cnt_next;
						upto_q  <= go_last ? cnt_next - 1'b1 : cnt_next - CW'(H + 1);
						zero_q  <= go_last && (cnt_next < CW'(WINDOW + 1));
						fin_q   <= go_last;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (dp_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (slot_free) begin
						if (at_end && fin_q) begin
							count_q    <= '0;
							emitted_q  <= '0;
							wr_idx_q   <= '0;
							emit_idx_q <= '0;
						end else begin
							emitted_q  <= emitted_q + 1'b1;
							emit_idx_q <= (emit_idx_q == RAW'(RING_DEPTH - 1)) ?
								'0 : emit_idx_q + 1'b1;
						end
						state_q <= at_end ? S_IDLE : S_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && slot_free) begin
			position_q <= lcbc_pkg::POS_W'(emitted_q);
			corr_q     <= dp_result;
			last_q     <= fin_q && at_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = position_q;
	assign correction  = corr_q;
	assign last_result = last_q;
	assign ring_widx   = wr_idx_q;
	assign pos         = emitted_q;
	assign pos_idx     = emit_idx_q;
	assign len         = len_q;

endmodule

// ===== sv/local_composition_bias_correction_core.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_stall       action table_row table_col score_value
//                                                background_value residue last
// out       output     out_valid / out_stall     position correction last_result
// cfg       input      cfg_valid / cfg_ready     cfg_data (alphabet_size)
//
// One item at a time. Table writes never stall the input. Each correction runs
// the window sweep over the residue ring, the alphabet sweep over the score and
// background memories, and the one-bit-per-cycle divider by the window span.
// A sequence shorter than WINDOW + 1 gives zero corrections without the sweeps.
// Reset clears counters and control; tables and ring hold no reset value.
// A stalled output holds the controller in its put state until the beat leaves.
module local_composition_bias_correction_core #(
	parameter int WINDOW       = lcbc_pkg::WINDOW_DEF,
	parameter int ALPHABET_MAX = lcbc_pkg::ALPHABET_MAX_DEF,
	parameter int RING_DEPTH   = lcbc_pkg::RING_DEPTH_DEF,
	parameter int MAX_LENGTH   = lcbc_pkg::MAX_LENGTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lcbc_pkg::ACTION_W-1:0]       action,
	input  logic [lcbc_pkg::LETTER_W-1:0]       table_row,
	input  logic [lcbc_pkg::LETTER_W-1:0]       table_col,
	input  logic signed [lcbc_pkg::SCORE_W-1:0] score_value,
	input  logic [lcbc_pkg::BG_W-1:0]           background_value,
	input  logic [lcbc_pkg::LETTER_W-1:0]       residue,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lcbc_pkg::POS_W-1:0]          position,
	output logic signed [lcbc_pkg::CORR_W-1:0]  correction,
	output logic                                last_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lcbc_pkg::ASZ_W-1:0]          cfg_data
);

	localparam int CW  = $clog2(MAX_LENGTH + 1);
	localparam int RAW = $clog2(RING_DEPTH);

	lcbc_pkg::cmd_t cmd;
	logic [lcbc_pkg::ASZ_W-1:0] alphabet_size_q;
	logic [RAW-1:0] ring_widx, pos_idx;
	logic [CW-1:0]  pos, len;
	logic           dp_done;
	logic signed [lcbc_pkg::CORR_W-1:0] dp_result;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_size_q <= lcbc_pkg::ASZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alphabet_size_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	lcbc_ctrl #(
		.WINDOW     (WINDOW),
		.RING_DEPTH (RING_DEPTH),
		.MAX_LENGTH (MAX_LENGTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.correction  (correction),
		.last_result (last_result),
		.cmd         (cmd),
		.ring_widx   (ring_widx),
		.pos         (pos),
		.pos_idx     (pos_idx),
		.len         (len),
		.dp_done     (dp_done),
		.dp_result   (dp_result)
	);

	lcbc_dp #(
		.WINDOW       (WINDOW),
		.ALPHABET_MAX (ALPHABET_MAX),
		.RING_DEPTH   (RING_DEPTH),
		.MAX_LENGTH   (MAX_LENGTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.alphabet_size    (alphabet_size_q),
		.table_row        (table_row),
		.table_col        (table_col),
		.score_value      (score_value),
		.background_value (background_value),
		.residue          (residue),
		.ring_widx        (ring_widx),
		.pos              (pos),
		.pos_idx          (pos_idx),
		.len              (len),
		.done             (dp_done),
		.result           (dp_result)
	);

endmodule

// ===== sv/lcbc_chk.sv =====
module lcbc_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [lcbc_pkg::ACTION_W-1:0]       action,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [lcbc_pkg::POS_W-1:0]          position,
	input logic signed [lcbc_pkg::CORR_W-1:0]  correction,
	input logic                                last_result
);

	// hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) &&
			$stable(correction) && $stable(last_result))
	else $error("stalled result beat changed");

	// table writes never block the next beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == lcbc_pkg::ACT_SCORE ||
			action == lcbc_pkg::ACT_BG) |=> !in_stall)
	else $error("table write stalled the input");

	// a new result appears only while the input side is held off
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
	else $error("result loaded while input was open");

endmodule

bind local_composition_bias_correction_core lcbc_chk u_chk (.*);
